// ===== rtl/fpool_pkg.sv =====
// Package for the fixed pool free-list allocator.
// Holds the request/result types, command and status codes and defaults.
// No dependencies.
package fpool_pkg;

    // Built depth of the link store
    localparam int MAX_RECORDS_DEF = 256;

    localparam int POOL_SIZE_W = 9;
    localparam int CMD_W       = 2;
    localparam int INDEX_W     = 8;
    localparam int STATUS_W    = 2;

    localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RST = 9'd256;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] record_index;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  granted_index;
        logic [INDEX_W-1:0]  free_head;
        logic                list_empty;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_INIT
    } t_state;

endpackage

// ===== rtl/fpool_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the link store. No dependencies.
module fpool_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fixed_pool_free_list_allocator.sv =====
// Top level of the fixed pool free-list allocator: sequencer, head register
// and link store. Depends on fpool_pkg and fpool_ram.
//
//  channel   | signals                        | handshake
//  ----------+--------------------------------+-------------------------------
//  request   | start, busy, i_req             | taken when start && !busy
//  result    | o_done, o_result               | one-cycle strobe, no stall
//  config    | i_cfg_we, i_cfg_wdata          | written when i_cfg_we
//
// Allocate, release and the unused command pass through S_EXEC: the accept cycle
// reads the head's link (allocate) or the released slot's link, the execute
// cycle updates it, and the result strobe follows. Initialise writes one link
// per cycle, bound by the single write port.
// Synchronous active-low reset empties the list and sets pool_size to 256;
// the link store is not cleared. The result side cannot stall.
module fixed_pool_free_list_allocator #(
    parameter int MAX_RECORDS = fpool_pkg::MAX_RECORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  fpool_pkg::t_request           i_req,
    output logic                          o_done,
    output fpool_pkg::t_result            o_result,
    input  logic                          i_cfg_we,
    input  logic [fpool_pkg::POOL_SIZE_W-1:0] i_cfg_wdata
);

    import fpool_pkg::*;

    // Slot address width, link width (slot, end marker, allocated marker),
    // and a size width wide enough for pool_size and MAX_RECORDS itself.
    localparam int AW  = $clog2(MAX_RECORDS);
    localparam int LW  = $clog2(MAX_RECORDS + 2);
    localparam int CW0 = $clog2(MAX_RECORDS + 1);
    localparam int SW  = (CW0 > POOL_SIZE_W) ? CW0 : POOL_SIZE_W;

    localparam logic [LW-1:0] LINK_END   = LW'(MAX_RECORDS);
    localparam logic [LW-1:0] LINK_ALLOC = LW'(MAX_RECORDS + 1);
    localparam logic [SW-1:0] SIZE_MAX   = SW'(MAX_RECORDS);

    // Control and state registers
    t_state                  r_state, n_state;
    logic [CMD_W-1:0]        r_cmd;
    logic [INDEX_W-1:0]      r_idx;
    logic [AW-1:0]           r_head, n_head;
    logic                    r_head_valid, n_head_valid;
    logic [SW-1:0]           r_cnt, n_cnt;
    logic [POOL_SIZE_W-1:0]  r_pool;
    t_result                 r_result, n_result;
    logic                    r_done, n_done;

    // Link store port
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [LW-1:0]           ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [LW-1:0]           ram_rdata;

    // Derived values
    logic                    accept;
    logic [SW-1:0]           pool_ext;
    logic [SW-1:0]           eff_size;
    logic [SW-1:0]           cnt_p1;
    logic                    init_last;
    logic [SW-1:0]           req_idx_ext;
    logic [SW-1:0]           idx_ext;
    logic [SW-1:0]           head_ext;
    logic [SW-1:0]           n_head_ext;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Effective pool size: 0 acts as 1, clamp at the built depth
    assign pool_ext = SW'(r_pool);
    always_comb begin
        if (pool_ext == '0) begin
            eff_size = SW'(1);
        end else if (pool_ext > SIZE_MAX) begin
            eff_size = SIZE_MAX;
        end else begin
            eff_size = pool_ext;
        end
    end

    assign cnt_p1      = r_cnt + SW'(1);
    assign init_last   = (cnt_p1 == eff_size);
    assign req_idx_ext = SW'(i_req.record_index);
    assign idx_ext     = SW'(r_idx);
    assign head_ext    = SW'(r_head);
    assign n_head_ext  = SW'(n_head);

    fpool_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_RECORDS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Read address is presented in the accept cycle
    assign ram_raddr = (i_req.cmd == CMD_ALLOC) ? r_head : req_idx_ext[AW-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_req.cmd == CMD_INIT) ? S_INIT : S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            S_INIT: begin
                if (init_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_cnt        = r_cnt;
        n_done       = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_head;
        ram_wdata    = LINK_ALLOC;
        n_result.status        = ST_OK;
        n_result.granted_index = '0;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
            end
            S_EXEC: begin
                n_done = 1'b1;
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (!r_head_valid) begin
                            n_result.status = ST_EXHAUSTED;
                        end else begin
                            ram_we                 = 1'b1;
                            ram_waddr              = r_head;
                            ram_wdata              = LINK_ALLOC;
                            n_result.granted_index = head_ext[INDEX_W-1:0];
                            if (ram_rdata < LINK_END) begin
                                n_head = ram_rdata[AW-1:0];
                            end else begin
                                n_head       = '0;
                                n_head_valid = 1'b0;
                            end
                        end
                    end
                    CMD_RELEASE: begin
                        if (idx_ext >= eff_size) begin
                            n_result.status = ST_RANGE;
                        end else if (ram_rdata != LINK_ALLOC) begin
                            n_result.status = ST_NOT_ALLOC;
                        end else begin
                            ram_we       = 1'b1;
                            ram_waddr    = idx_ext[AW-1:0];
                            ram_wdata    = r_head_valid ? LW'(r_head) : LINK_END;
                            n_head       = idx_ext[AW-1:0];
                            n_head_valid = 1'b1;
                        end
                    end
                    default: begin
                        // unused command: no change
                    end
                endcase
            end
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = init_last ? LINK_END : LW'(cnt_p1);
                n_cnt     = cnt_p1;
                if (init_last) begin
                    n_done       = 1'b1;
                    n_head       = '0;
                    n_head_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_result.free_head  = n_head_valid ? n_head_ext[INDEX_W-1:0] : '0;
        n_result.list_empty = !n_head_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_pool       <= POOL_SIZE_RST;
            r_done       <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_head_valid <= n_head_valid;
            r_done       <= n_done;
            r_cnt        <= n_cnt;
            if (i_cfg_we) begin
                r_pool <= i_cfg_wdata;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_req.cmd;
            r_idx <= i_req.record_index;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted request did not start the sequencer");

    a_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_EXHAUSTED) |->
            (o_result.list_empty && o_result.granted_index == '0))
        else $error("exhausted result with non-empty list or a grant");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.list_empty) |-> (o_result.free_head == '0))
        else $error("empty list reports a nonzero head");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != S_IDLE))
        else $error("link store written while idle");
`endif

endmodule

// ===== tb/fixed_pool_free_list_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fixed_pool_free_list_allocator: directed table, then random requests.
// Every result is checked against a hand-written value or a slot-pool model kept in this file.
// Depends on fpool_pkg and the allocator RTL.
module fixed_pool_free_list_allocator_tb;
    import fpool_pkg::*;

    // Command 3 is not decoded by the block; it must leave the list untouched
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Link encodings of the pool model: next free slot, end of list, handed out
    localparam logic [8:0] LINK_END   = 9'(MAX_RECORDS_DEF);
    localparam logic [8:0] LINK_ALLOC = 9'(MAX_RECORDS_DEF + 1);

    // Longest quiet stretch of a correct run is an initialise of the full pool
    // plus a sender gap and the pause around a register write;
    // the limit takes that several times over.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_REQS     = 75;
    localparam int NUM_PHASES     = 12;

    // One row of the directed plan: optional pool_size write before the request,
    // and a hand-written result where it is obvious, else the model decides.
    typedef struct {
        bit                     set_cfg;
        logic [POOL_SIZE_W-1:0] cfg_val;
        t_request               req;
        bit                     typed;
        t_result                want;
    } t_plan_row;

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_request i_req = '0;
    logic     o_done;
    t_result  o_result;
    logic     i_cfg_we = 1'b0;
    logic [POOL_SIZE_W-1:0] i_cfg_wdata = '0;

    fixed_pool_free_list_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Pool model: link per slot, list head, pool_size register
    // ------------------------------------------------------------------
    logic [8:0]             slot_link [MAX_RECORDS_DEF];
    logic [INDEX_W-1:0]     head_slot = '0;
    logic                   head_live = 1'b0;
    logic [POOL_SIZE_W-1:0] pool_size_reg = POOL_SIZE_RST;

    t_result pending_results [$];
    int      err_cnt = 0;
    int      idle_pct = 21;
    int      stall_cycles = 0;

    // pool_size is clamped to 1 .. built depth
    function automatic int live_slots();
        int n;
        n = int'(pool_size_reg);
        if (n < 1) n = 1;
        if (n > MAX_RECORDS_DEF) n = MAX_RECORDS_DEF;
        return n;
    endfunction

    // Applies one request to the pool model and returns the result it yields
    function automatic t_result pool_step(input t_request req);
        t_result    r;
        int         n;
        logic [8:0] nxt;
        r = '0;
        r.status = ST_OK;
        n = live_slots();
        case (req.cmd)
            CMD_INIT: begin
                for (int i = 0; i < n; i++)
                    slot_link[i] = (i + 1 < n) ? 9'(i + 1) : LINK_END;
                head_slot = '0;
                head_live = 1'b1;
            end
            CMD_ALLOC: begin
                if (!head_live) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    nxt = slot_link[head_slot];
                    slot_link[head_slot] = LINK_ALLOC;
                    r.granted_index = head_slot;
                    if (nxt < LINK_END) begin
                        head_slot = nxt[INDEX_W-1:0];
                    end else begin
                        head_slot = '0;
                        head_live = 1'b0;
                    end
                end
            end
            CMD_RELEASE: begin
                if (int'(req.record_index) >= n) begin
                    r.status = ST_RANGE;
                end else if (slot_link[req.record_index] != LINK_ALLOC) begin
                    r.status = ST_NOT_ALLOC;   // double free or never handed out
                end else begin
                    slot_link[req.record_index] = head_live ? {1'b0, head_slot} : LINK_END;
                    head_slot = req.record_index;
                    head_live = 1'b1;
                end
            end
            default: ;
        endcase
        r.free_head  = head_live ? head_slot : '0;
        r.list_empty = !head_live;
        return r;
    endfunction

    // Some slot currently handed out, scanning from a random point; -1 if none
    function automatic int find_granted();
        int first;
        int s;
        first = $urandom_range(0, MAX_RECORDS_DEF - 1);
        for (int k = 0; k < MAX_RECORDS_DEF; k++) begin
            s = (first + k) % MAX_RECORDS_DEF;
            if (slot_link[s] == LINK_ALLOC) return s;
        end
        return -1;
    endfunction

    // Random mix: mostly allocate / release of granted slots so the list
    // churns; a few double frees, range errors, re-inits and unused commands.
    function automatic t_request next_request();
        t_request req;
        int       roll;
        int       slot;
        roll = $urandom_range(0, 99);
        req.cmd = CMD_RELEASE;
        req.record_index = 8'($urandom_range(0, 255));
        if (roll < 2) begin
            req.cmd = CMD_INIT;
        end else if (roll < 4) begin
            req.cmd = CMD_UNUSED;
        end else if (roll < 48) begin
            req.cmd = CMD_ALLOC;
        end else if (roll < 88) begin
            slot = find_granted();
            if (slot >= 0) req.record_index = 8'(slot);
            else req.cmd = CMD_ALLOC;
        end else if (roll < 94) begin
            // in range, mostly a slot that is still free
            req.record_index = 8'($urandom_range(0, live_slots() - 1));
        end
        return req;
    endfunction

    function automatic t_plan_row mk_row(input bit set_cfg, input int cfg_val,
                                         input logic [CMD_W-1:0] cmd, input int idx,
                                         input bit typed, input logic [STATUS_W-1:0] st,
                                         input int granted, input int head, input bit empty);
        t_plan_row row;
        row.set_cfg = set_cfg;
        row.cfg_val = 9'(cfg_val);
        row.req.cmd = cmd;
        row.req.record_index = 8'(idx);
        row.typed = typed;
        row.want.status = st;
        row.want.granted_index = 8'(granted);
        row.want.free_head = 8'(head);
        row.want.list_empty = empty;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    // Holds start until the request is taken (start && !busy at an edge), then
    // records the expectation. start stays high when no gap follows, so a new
    // request goes out on the very next cycle.
    task automatic issue(input t_request req, input bit typed, input t_result fixed);
        t_result predicted;
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = pool_step(req);
        pending_results.push_back(typed ? fixed : predicted);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Let every outstanding request finish before pool_size is touched
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pool_size(input logic [POOL_SIZE_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pool_size_reg = value;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %p", o_result);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    err_cnt++;
                end
                if (o_result.granted_index !== want.granted_index) begin
                    $error("granted_index: expected %0d, got %0d",
                           want.granted_index, o_result.granted_index);
                    err_cnt++;
                end
                if (o_result.free_head !== want.free_head) begin
                    $error("free_head: expected %0d, got %0d",
                           want.free_head, o_result.free_head);
                    err_cnt++;
                end
                if (o_result.list_empty !== want.list_empty) begin
                    $error("list_empty: expected %0d, got %0d",
                           want.list_empty, o_result.list_empty);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: any taken request or result strobe counts as progress
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("fixed_pool_free_list_allocator: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_plan_row              plan [$];
        t_plan_row              row;
        logic [POOL_SIZE_W-1:0] phase_size [NUM_PHASES];

        for (int i = 0; i < MAX_RECORDS_DEF; i++) slot_link[i] = '0;

        // Directed: empty pool before any initialise, full pool, double free,
        // range errors, shrinking and growing pool_size, clamped sizes 0 and
        // above the built depth, and the unused command.
        plan.push_back(mk_row(0,   0, CMD_ALLOC,     0, 1, ST_EXHAUSTED, 0, 0, 1));
        plan.push_back(mk_row(0,   0, CMD_UNUSED,  255, 1, ST_OK,        0, 0, 1));
        plan.push_back(mk_row(0,   0, CMD_INIT,      0, 1, ST_OK,        0, 0, 0));
        plan.push_back(mk_row(0,   0, CMD_ALLOC,     0, 1, ST_OK,        0, 1, 0));
        plan.push_back(mk_row(0,   0, CMD_ALLOC,     0, 1, ST_OK,        1, 2, 0));
        plan.push_back(mk_row(0,   0, CMD_RELEASE,   0, 1, ST_OK,        0, 0, 0));
        plan.push_back(mk_row(0,   0, CMD_RELEASE,   0, 1, ST_NOT_ALLOC, 0, 0, 0));
        plan.push_back(mk_row(0,   0, CMD_RELEASE, 255, 1, ST_NOT_ALLOC, 0, 0, 0));
        plan.push_back(mk_row(1,   4, CMD_ALLOC,     0, 0, ST_OK,        0, 0, 0));
        plan.push_back(mk_row(0,   0, CMD_RELEASE,   4, 1, ST_RANGE,     0, 2, 0));
        plan.push_back(mk_row(1,   1, CMD_INIT,      0, 1, ST_OK,        0, 0, 0));
        plan.push_back(mk_row(0,   0, CMD_ALLOC,     0, 1, ST_OK,        0, 0, 1));
        plan.push_back(mk_row(0,   0, CMD_ALLOC,     0, 1, ST_EXHAUSTED, 0, 0, 1));
        plan.push_back(mk_row(0,   0, CMD_RELEASE,   1, 1, ST_RANGE,     0, 0, 1));
        plan.push_back(mk_row(0,   0, CMD_RELEASE,   0, 1, ST_OK,        0, 0, 0));
        plan.push_back(mk_row(1,   0, CMD_INIT,      0, 1, ST_OK,        0, 0, 0));
        plan.push_back(mk_row(0,   0, CMD_ALLOC,     0, 1, ST_OK,        0, 0, 1));
        plan.push_back(mk_row(0,   0, CMD_RELEASE,   1, 1, ST_RANGE,     0, 0, 1));
        plan.push_back(mk_row(1, 511, CMD_INIT,      0, 1, ST_OK,        0, 0, 0));
        plan.push_back(mk_row(0,   0, CMD_RELEASE, 255, 1, ST_NOT_ALLOC, 0, 0, 0));
        plan.push_back(mk_row(0,   0, CMD_ALLOC,     0, 1, ST_OK,        0, 1, 0));
        plan.push_back(mk_row(1, 257, CMD_RELEASE,   0, 1, ST_OK,        0, 0, 0));
        plan.push_back(mk_row(0,   0, CMD_UNUSED,  170, 1, ST_OK,        0, 0, 0));
        plan.push_back(mk_row(0,   0, CMD_UNUSED,   85, 0, ST_OK,        0, 0, 0));
        plan.push_back(mk_row(1,   2, CMD_INIT,      0, 0, ST_OK,        0, 0, 0));
        plan.push_back(mk_row(0,   0, CMD_ALLOC,     0, 0, ST_OK,        0, 0, 0));

        // Mostly small pools; the full and clamped sizes appear a few times
        phase_size = '{9'd8, 9'd256, 9'd1, 9'd3, 9'd0, 9'd511,
                       9'd257, 9'd40, 9'd2, 9'd100, 9'd16, 9'd5};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No release is sent before the first initialise: links of a slot
        // never chained are undefined in the block.
        foreach (plan[k]) begin
            row = plan[k];
            if (row.set_cfg) write_pool_size(row.cfg_val);
            issue(row.req, row.typed, row.want);
        end

        // The directed part chained all slots once, so every link is defined
        // from here on. Sender pauses after 21% of requests, then 49%, then never.
        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_pct = (p < 4) ? 21 : (p < 8) ? 49 : 0;
            write_pool_size(phase_size[p]);
            // usually rebuild the list; sometimes keep the old one across
            // the size change
            if ($urandom_range(0, 3) != 0)
                issue('{cmd: CMD_INIT, record_index: 8'd0}, 1'b0, '0);
            repeat (PHASE_REQS) issue(next_request(), 1'b0, '0);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("fixed_pool_free_list_allocator: match");
        else
            $display("fixed_pool_free_list_allocator: mismatch");
        $finish;
    end

endmodule
